/* sv/triangle_edge_function_rasterizer_top_assert.svh */
// Assertion macros for the triangle rasteriser.
// TEFR_ASSERT_IMP: the consequent holds in the same cycle as the antecedent.
// TEFR_ASSERT_NXT: the consequent holds in the cycle after the antecedent.
`ifndef TRIANGLE_EDGE_FUNCTION_RASTERIZER_TOP_ASSERT_SVH
`define TRIANGLE_EDGE_FUNCTION_RASTERIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TEFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tefr: same-cycle check failed");
`define TEFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tefr: next-cycle check failed");
`else
`define TEFR_ASSERT_IMP(lbl, ante, cons)
`define TEFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/tefr_pkg.sv */
`timescale 1ns / 1ps

package tefr_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int SUBPIXEL_BITS_DEF = 4;

    localparam int PIX_W      = 12;
    localparam int FRAME_W    = 13;
    localparam int WEIGHT_W   = 35;
    localparam int AREA_W     = 34;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int OUT_BITS    = 2 * PIX_W + 1 + 3 * WEIGHT_W + AREA_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FRAME_W-1:0] FRAME_MAX        = 13'd4096;
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED    = 3'd0,
        ST_CULLED      = 3'd1,
        ST_DEGENERATE  = 3'd2,
        ST_COVERED     = 3'd3,
        ST_NOT_COVERED = 3'd4,
        ST_NO_TRIANGLE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CULL_NONE  = 2'd0,
        CULL_FRONT = 2'd1,
        CULL_BACK  = 2'd2,
        CULL_BOTH  = 2'd3
    } cull_mode_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CULL_MODE     = 2'd2,
        REG_FRONT_WINDING = 2'd3
    } reg_index_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic WIND_CCW = 1'b0;
    localparam logic WIND_CW  = 1'b1;

endpackage

/* sv/triangle_edge_function_rasterizer_top.sv */
`timescale 1ns / 1ps
// Edge-function triangle rasteriser with the top-left fill rule.
// Input stream (s_*): s_tuser selects the request, 0 loads a triangle whose
// three fixed-point vertices sit in s_tdata, 1 steps one pixel of the loaded
// triangle's clipped bounding box in raster order. Every beat gives exactly
// one output beat (m_*): m_tuser carries the status, m_tdata the pixel, the
// facing, an edge weight for each edge and the doubled area, m_tlast marks the
// final pixel of the box (or a load whose box is empty).
// The APB port sets frame width/height, cull mode and front winding; write it
// only while no beat is in flight. pready is tied high.
// A beat passes the input, product and output registers in turn. Throughput
// is one beat per clock for loads and steps alike while the output does not
// stall; a step straight after a load sees the new triangle, as the triangle
// state updates in the last stage. When m_tready is low the three stages
// fill up and s_tready falls once all of them hold a beat; bubbles are
// squeezed out while stalled.
// Reset drops any loaded triangle, empties the pipeline and returns the
// registers to 640 x 480, no culling, counter-clockwise front faces.
`include "triangle_edge_function_rasterizer_top_assert.svh"

module triangle_edge_function_rasterizer_top #(
    parameter int COORD_BITS    = tefr_pkg::COORD_BITS_DEF,
    parameter int SUBPIXEL_BITS = tefr_pkg::SUBPIXEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // req_type
    input  logic                                   s_tuser,
    // output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pixel_x, pixel_y, front_facing, weight_a, weight_b, weight_c,
    // double_area, zero pad
    output logic [tefr_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // status
    output logic [tefr_pkg::STATUS_W-1:0]          m_tuser,
    output logic                                   m_tlast,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tefr_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [tefr_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [tefr_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int CB   = COORD_BITS;
    localparam int SB   = SUBPIXEL_BITS;
    localparam int EW   = CB + 1;
    localparam int PW   = CB + 2;
    localparam int PRW  = PW + EW;
    localparam int SPW  = 2 * EW;
    localparam int SW   = PRW + 1;
    localparam int WL   = tefr_pkg::WEIGHT_W;
    localparam int AL   = tefr_pkg::AREA_W;
    localparam int PXW  = tefr_pkg::PIX_W;
    localparam int FW   = tefr_pkg::FRAME_W;
    localparam int IW   = (SW > WL) ? SW : WL;
    localparam int DW   = EW + SB + 1;
    localparam int WW   = (CB + 1 > FW) ? CB + 1 : FW;
    localparam int OTW  = tefr_pkg::OUT_TDATA_W;
    localparam logic [CB:0] ONE_M1_V = (CB+1)'((1 << SB) - 1);
    localparam logic [CB:0] HALF_V   = (CB+1)'((1 << SB) >> 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW-1:0]          frame_width_reg;
    logic [FW-1:0]          frame_height_reg;
    tefr_pkg::cull_mode_t   cull_mode_reg;
    logic                   front_winding_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= tefr_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= tefr_pkg::FRAME_HEIGHT_RST;
            cull_mode_reg     <= tefr_pkg::CULL_NONE;
            front_winding_reg <= tefr_pkg::WIND_CCW;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                tefr_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[FW-1:0];
                tefr_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[FW-1:0];
                tefr_pkg::REG_CULL_MODE:     cull_mode_reg     <= tefr_pkg::cull_mode_t'(pwdata[1:0]);
                tefr_pkg::REG_FRONT_WINDING: front_winding_reg <= pwdata[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tefr_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_reg);
            tefr_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            tefr_pkg::REG_CULL_MODE:     prdata = 32'(cull_mode_reg);
            tefr_pkg::REG_FRONT_WINDING: prdata = 32'(front_winding_reg);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, mv_reg;
    logic out_free, s1_free, s0_free, adv1, accept;

    assign out_free = !mv_reg || m_tready;
    assign adv1     = v1_reg && out_free;
    assign s1_free  = !v1_reg || out_free;
    assign s0_free  = !v0_reg || s1_free;
    assign s_tready = s0_free;
    assign accept   = s_tvalid && s0_free;
    assign m_tvalid = mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            mv_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
                v0_reg <= s_tvalid;
            if (s1_free)
                v1_reg <= v0_reg;
            if (out_free)
                mv_reg <= v1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register, edges, bounding box and edge products
    // ------------------------------------------------------------------
    logic           req0_reg;
    logic [CB-1:0]  vx_reg [3];
    logic [CB-1:0]  vy_reg [3];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req0_reg <= s_tuser;
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= s_tdata[(2*i)*CB +: CB];
                vy_reg[i] <= s_tdata[(2*i+1)*CB +: CB];
            end
        end
    end

    logic signed [EW-1:0]  ex [3];
    logic signed [EW-1:0]  ey [3];
    logic signed [PW-1:0]  offx [3];
    logic signed [PW-1:0]  offy [3];
    logic signed [PRW-1:0] gpa [3];
    logic signed [PRW-1:0] gpb [3];
    logic signed [SPW-1:0] sp0, sp1;
    logic [CB-1:0]         mnx, mxx, mny, mxy;
    logic [CB-1:0]         mnx_fl, mny_fl;
    logic [CB:0]           pcx, pcy;
    logic [CB-1:0]         bx0, by0;
    logic [CB:0]           bx1_raw, by1_raw;
    logic [FW-1:0]         fw_clip, fh_clip;
    logic [WW-1:0]         bx1_w, by1_w;
    logic                  empty0;

    always_comb
    begin
        mnx = vx_reg[0];
        mxx = vx_reg[0];
        mny = vy_reg[0];
        mxy = vy_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx_reg[i] < mnx) mnx = vx_reg[i];
            if (vx_reg[i] > mxx) mxx = vx_reg[i];
            if (vy_reg[i] < mny) mny = vy_reg[i];
            if (vy_reg[i] > mxy) mxy = vy_reg[i];
        end
    end

    // first pixel centre of the box, in subpixel units
    assign mnx_fl  = (mnx >> SB) << SB;
    assign mny_fl  = (mny >> SB) << SB;
    assign pcx     = {1'b0, mnx_fl} + HALF_V;
    assign pcy     = {1'b0, mny_fl} + HALF_V;
    assign bx0     = mnx >> SB;
    assign by0     = mny >> SB;
    assign bx1_raw = ({1'b0, mxx} + ONE_M1_V) >> SB;
    assign by1_raw = ({1'b0, mxy} + ONE_M1_V) >> SB;

    assign fw_clip = (frame_width_reg  > tefr_pkg::FRAME_MAX) ? tefr_pkg::FRAME_MAX
                                                              : frame_width_reg;
    assign fh_clip = (frame_height_reg > tefr_pkg::FRAME_MAX) ? tefr_pkg::FRAME_MAX
                                                              : frame_height_reg;
    assign bx1_w   = (WW'(bx1_raw) < WW'(fw_clip)) ? WW'(bx1_raw) : WW'(fw_clip);
    assign by1_w   = (WW'(by1_raw) < WW'(fh_clip)) ? WW'(by1_raw) : WW'(fh_clip);
    assign empty0  = (WW'(bx0) >= bx1_w) || (WW'(by0) >= by1_w);

    // Edge j runs from vertex j to vertex j+1 in input order; its edge
    // function is evaluated at the first pixel centre.
    for (genvar g = 0; g < 3; g++)
    begin : g_edge
        localparam int N = (g + 1) % 3;
        assign ex[g]   = $signed({1'b0, vx_reg[N]}) - $signed({1'b0, vx_reg[g]});
        assign ey[g]   = $signed({1'b0, vy_reg[N]}) - $signed({1'b0, vy_reg[g]});
        assign offx[g] = $signed({1'b0, pcx}) - $signed({2'b00, vx_reg[g]});
        assign offy[g] = $signed({1'b0, pcy}) - $signed({2'b00, vy_reg[g]});
        assign gpa[g]  = offx[g] * ey[g];
        assign gpb[g]  = offy[g] * ex[g];
    end

    // winding cross product (v1-v0) x (v2-v0), edge 2 being v0-v2
    assign sp0 = ey[0] * ex[2];
    assign sp1 = ex[0] * ey[2];

    // ------------------------------------------------------------------
    // Stage 1 register
    // ------------------------------------------------------------------
    logic                  req1_reg;
    logic signed [SPW-1:0] sp0_reg, sp1_reg;
    logic signed [PRW-1:0] gpa_reg [3];
    logic signed [PRW-1:0] gpb_reg [3];
    logic signed [EW-1:0]  ex_reg [3];
    logic signed [EW-1:0]  ey_reg [3];
    logic [PXW-1:0]        bx0_reg, by0_reg;
    logic [FW-1:0]         bx1_reg, by1_reg;
    logic                  empty1_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free && v0_reg)
        begin
            req1_reg   <= req0_reg;
            sp0_reg    <= sp0;
            sp1_reg    <= sp1;
            gpa_reg    <= gpa;
            gpb_reg    <= gpb;
            ex_reg     <= ex;
            ey_reg     <= ey;
            bx0_reg    <= PXW'(bx0);
            by0_reg    <= PXW'(by0);
            bx1_reg    <= FW'(bx1_w);
            by1_reg    <= FW'(by1_w);
            empty1_reg <= empty0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: facing, cull, reorder, weights and pixel stepping
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s1, area1;
    logic                 s_pos, s_neg, s_zero, front1, cull1;
    logic signed [SW-1:0] g_pos [3];
    logic signed [SW-1:0] g_neg [3];
    logic signed [DW-1:0] ex_s [3];
    logic signed [DW-1:0] ey_s [3];
    logic signed [IW-1:0] w_load [3];
    logic signed [DW-1:0] dx_load [3];
    logic signed [DW-1:0] dy_load [3];
    logic [2:0]           tl_load;

    assign s1     = sp0_reg - sp1_reg;
    assign s_neg  = s1[SW-1];
    assign s_zero = (s1 == '0);
    assign s_pos  = !s_neg && !s_zero;
    assign area1  = s_neg ? -s1 : s1;
    assign front1 = (s_neg && (front_winding_reg == tefr_pkg::WIND_CCW))
                 || (s_pos && (front_winding_reg == tefr_pkg::WIND_CW));
    assign cull1  = (cull_mode_reg == tefr_pkg::CULL_BOTH)
                 || ((cull_mode_reg == tefr_pkg::CULL_FRONT) && front1)
                 || ((cull_mode_reg == tefr_pkg::CULL_BACK) && !front1);

    // A clockwise triangle swaps vertices 1 and 2: every reordered edge is
    // an input edge reversed, so its function and deltas only flip sign.
    for (genvar g = 0; g < 3; g++)
    begin : g_weight
        localparam int SRC_U = (g + 1) % 3;
        localparam int SRC_S = (g == 0) ? 1 : ((g == 1) ? 0 : 2);
        assign g_pos[g]   = gpa_reg[g] - gpb_reg[g];
        assign g_neg[g]   = gpb_reg[g] - gpa_reg[g];
        assign ex_s[g]    = DW'(ex_reg[g]) <<< SB;
        assign ey_s[g]    = DW'(ey_reg[g]) <<< SB;
        assign w_load[g]  = s_pos ? IW'(g_neg[SRC_S]) : IW'(g_pos[SRC_U]);
        assign dx_load[g] = s_pos ? -ey_s[SRC_S] : ey_s[SRC_U];
        assign dy_load[g] = s_pos ? ex_s[SRC_S] : -ex_s[SRC_U];
        assign tl_load[g] = s_pos
            ? ((ey_reg[SRC_S] < 0) || ((ey_reg[SRC_S] == 0) && (ex_reg[SRC_S] > 0)))
            : ((ey_reg[SRC_U] > 0) || ((ey_reg[SRC_U] == 0) && (ex_reg[SRC_U] < 0)));
    end

    // triangle state
    logic                 active_reg, active_next;
    logic signed [IW-1:0] wnow_reg [3];
    logic signed [IW-1:0] wnow_next [3];
    logic signed [IW-1:0] wrow_reg [3];
    logic signed [IW-1:0] wrow_next [3];
    logic signed [DW-1:0] dx_reg [3];
    logic signed [DW-1:0] dx_next [3];
    logic signed [DW-1:0] dy_reg [3];
    logic signed [DW-1:0] dy_next [3];
    logic [2:0]           tl_reg, tl_next;
    logic [PXW-1:0]       box_min_x_reg, box_min_x_next;
    logic [FW-1:0]        box_max_x_reg, box_max_x_next;
    logic [FW-1:0]        box_max_y_reg, box_max_y_next;
    logic [PXW-1:0]       cursor_x_reg, cursor_x_next;
    logic [PXW-1:0]       cursor_y_reg, cursor_y_next;
    logic                 front_reg, front_next;
    logic [AL-1:0]        area_reg, area_next;

    logic [FW-1:0]        cur_x_w, cur_y_w, xp1, yp1;
    logic                 row_end, col_end, last_pix, covered;

    assign cur_x_w  = {1'b0, cursor_x_reg};
    assign cur_y_w  = {1'b0, cursor_y_reg};
    assign xp1      = cur_x_w + 1'b1;
    assign yp1      = cur_y_w + 1'b1;
    assign row_end  = (xp1 >= box_max_x_reg);
    assign col_end  = (yp1 >= box_max_y_reg);
    assign last_pix = row_end && col_end;

    always_comb
    begin
        covered = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (!((wnow_reg[i] > 0) || ((wnow_reg[i] == 0) && tl_reg[i])))
                covered = 1'b0;
        end
    end

    // output register
    tefr_pkg::status_t    out_status_reg, out_status_next;
    logic [PXW-1:0]       out_px_reg, out_px_next;
    logic [PXW-1:0]       out_py_reg, out_py_next;
    logic                 out_front_reg, out_front_next;
    logic signed [WL-1:0] out_w_reg [3];
    logic signed [WL-1:0] out_w_next [3];
    logic [AL-1:0]        out_area_reg, out_area_next;
    logic                 out_last_reg, out_last_next;

    always_comb
    begin
        active_next    = active_reg;
        wnow_next      = wnow_reg;
        wrow_next      = wrow_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        tl_next        = tl_reg;
        box_min_x_next = box_min_x_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        front_next     = front_reg;
        area_next      = area_reg;

        out_status_next = tefr_pkg::ST_NO_TRIANGLE;
        out_px_next     = '0;
        out_py_next     = '0;
        out_front_next  = 1'b0;
        out_area_next   = '0;
        out_last_next   = 1'b0;
        for (int i = 0; i < 3; i++)
            out_w_next[i] = '0;

        if (req1_reg == tefr_pkg::REQ_LOAD)
        begin
            // any earlier triangle is dropped by a load
            active_next    = 1'b0;
            out_front_next = front1;
            if (cull1)
                out_status_next = tefr_pkg::ST_CULLED;
            else if (s_zero)
                out_status_next = tefr_pkg::ST_DEGENERATE;
            else
            begin
                out_status_next = tefr_pkg::ST_ACCEPTED;
                out_px_next     = bx0_reg;
                out_py_next     = by0_reg;
                out_area_next   = AL'(area1);
                out_last_next   = empty1_reg;
                for (int i = 0; i < 3; i++)
                    out_w_next[i] = WL'(w_load[i]);

                active_next    = !empty1_reg;
                wnow_next      = w_load;
                wrow_next      = w_load;
                dx_next        = dx_load;
                dy_next        = dy_load;
                tl_next        = tl_load;
                box_min_x_next = bx0_reg;
                box_max_x_next = bx1_reg;
                box_max_y_next = by1_reg;
                cursor_x_next  = bx0_reg;
                cursor_y_next  = by0_reg;
                front_next     = front1;
                area_next      = AL'(area1);
            end
        end
        else if (active_reg)
        begin
            out_status_next = covered ? tefr_pkg::ST_COVERED : tefr_pkg::ST_NOT_COVERED;
            out_px_next     = cursor_x_reg;
            out_py_next     = cursor_y_reg;
            out_front_next  = front_reg;
            out_area_next   = area_reg;
            out_last_next   = last_pix;
            for (int i = 0; i < 3; i++)
                out_w_next[i] = WL'(wnow_reg[i]);

            if (!row_end)
            begin
                cursor_x_next = xp1[PXW-1:0];
                for (int i = 0; i < 3; i++)
                    wnow_next[i] = wnow_reg[i] + IW'(dx_reg[i]);
            end
            else
            begin
                // wrap to the start of the next row
                cursor_x_next = box_min_x_reg;
                cursor_y_next = yp1[PXW-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    wrow_next[i] = wrow_reg[i] + IW'(dy_reg[i]);
                    wnow_next[i] = wrow_reg[i] + IW'(dy_reg[i]);
                end
                if (col_end)
                    active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (adv1)
            active_reg <= active_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            wnow_reg       <= wnow_next;
            wrow_reg       <= wrow_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            tl_reg         <= tl_next;
            box_min_x_reg  <= box_min_x_next;
            box_max_x_reg  <= box_max_x_next;
            box_max_y_reg  <= box_max_y_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            front_reg      <= front_next;
            area_reg       <= area_next;

            out_status_reg <= out_status_next;
            out_px_reg     <= out_px_next;
            out_py_reg     <= out_py_next;
            out_front_reg  <= out_front_next;
            out_w_reg      <= out_w_next;
            out_area_reg   <= out_area_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tdata = OTW'({out_area_reg, out_w_reg[2], out_w_reg[1], out_w_reg[0],
                           out_front_reg, out_py_reg, out_px_reg});
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TEFR_ASSERT_IMP(a_ready_only_when_full, !s_tready, v0_reg && v1_reg && mv_reg)
    `TEFR_ASSERT_IMP(a_cursor_in_box, active_reg, (cur_x_w < box_max_x_reg) && (cur_y_w < box_max_y_reg))
    `TEFR_ASSERT_NXT(a_idle_step, adv1 && (req1_reg == tefr_pkg::REQ_STEP) && !active_reg, m_tuser == tefr_pkg::ST_NO_TRIANGLE)
    `TEFR_ASSERT_NXT(a_last_drops, adv1 && (req1_reg == tefr_pkg::REQ_STEP) && active_reg && last_pix, !active_reg && m_tlast)

endmodule

/* dv/tefr_coverage_checker.sv */
`timescale 1ns / 1ps

module tefr_coverage_checker
    import tefr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [95:0]              s_tdata,
    input  logic                     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_TDATA_W-1:0]   m_tdata,
    input  logic [STATUS_W-1:0]      m_tuser,
    input  logic                     m_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    input  logic                     pready,
    output int                       outstanding,
    output int                       mismatches
);

    localparam int     SUB  = SUBPIXEL_BITS_DEF;
    localparam longint ONE  = longint'(1) << SUB;
    localparam longint HALF = ONE >> 1;

    // output tdata layout, lowest bit first
    localparam int PY_AT = PIX_W;
    localparam int FF_AT = 2 * PIX_W;
    localparam int WA_AT = FF_AT + 1;
    localparam int WB_AT = WA_AT + WEIGHT_W;
    localparam int WC_AT = WB_AT + WEIGHT_W;
    localparam int AR_AT = WC_AT + WEIGHT_W;

    typedef struct {
        status_t              st;
        logic [PIX_W-1:0]     px;
        logic [PIX_W-1:0]     py;
        logic                 ff;
        logic [WEIGHT_W-1:0]  wa;
        logic [WEIGHT_W-1:0]  wb;
        logic [WEIGHT_W-1:0]  wc;
        logic [AREA_W-1:0]    area;
        logic                 last;
    } pixel_answer_t;

    // register copies
    logic [FRAME_W-1:0] cfg_fw;
    logic [FRAME_W-1:0] cfg_fh;
    cull_mode_t         cfg_cull;
    logic               cfg_wind;

    // triangle being walked
    logic               tri_live;
    longint             dlt [6];
    logic [2:0]         tl_edges;
    longint             wnow [3];
    longint             wrow [3];
    longint             bmin_x, bmin_y, bmax_x, bmax_y;
    longint             cx, cy;
    logic               facing;
    logic [AREA_W-1:0]  area_r;

    pixel_answer_t expected_answers [$];
    pixel_answer_t oldest;

    function automatic pixel_answer_t make_answer(status_t st, longint px, longint py,
                                                  logic ff, longint w0, longint w1,
                                                  longint w2, longint ar, logic lst);
        pixel_answer_t a;
        a.st   = st;
        a.px   = px[PIX_W-1:0];
        a.py   = py[PIX_W-1:0];
        a.ff   = ff;
        a.wa   = w0[WEIGHT_W-1:0];
        a.wb   = w1[WEIGHT_W-1:0];
        a.wc   = w2[WEIGHT_W-1:0];
        a.area = ar[AREA_W-1:0];
        a.last = lst;
        return a;
    endfunction

    function automatic pixel_answer_t load_triangle(logic [95:0] d);
        longint vx [3];
        longint vy [3];
        longint ex [3];
        longint ey [3];
        longint s, ar, t, mnx, mny, mxx, mxy, px, py, fw, fh;
        logic   front, cull;
        int     k;
        tri_live = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = longint'(d[32*i +: 16]);
            vy[i] = longint'(d[32*i+16 +: 16]);
        end
        s = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
        // y grows downward, so a negative cross product is counter-clockwise
        front = (s < 0 && cfg_wind == WIND_CCW) || (s > 0 && cfg_wind == WIND_CW);
        cull  = (cfg_cull == CULL_BOTH) || (cfg_cull == CULL_FRONT && front)
                || (cfg_cull == CULL_BACK && !front);
        if (cull)
            return make_answer(ST_CULLED, 0, 0, front, 0, 0, 0, 0, 1'b0);
        if (s > 0)
        begin
            t = vx[1]; vx[1] = vx[2]; vx[2] = t;
            t = vy[1]; vy[1] = vy[2]; vy[2] = t;
        end
        for (int i = 0; i < 3; i++)
        begin
            ex[i] = vx[(i + 1) % 3] - vx[i];
            ey[i] = vy[(i + 1) % 3] - vy[i];
        end
        ar = ex[0] * ey[2] - ey[0] * ex[2];
        if (ar < 0)
            ar = -ar;
        if (ar == 0)
            return make_answer(ST_DEGENERATE, 0, 0, front, 0, 0, 0, 0, 1'b0);

        mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx[i] < mnx) mnx = vx[i];
            if (vx[i] > mxx) mxx = vx[i];
            if (vy[i] < mny) mny = vy[i];
            if (vy[i] > mxy) mxy = vy[i];
        end
        fw = (cfg_fw > FRAME_MAX) ? longint'(FRAME_MAX) : longint'(cfg_fw);
        fh = (cfg_fh > FRAME_MAX) ? longint'(FRAME_MAX) : longint'(cfg_fh);
        bmin_x = mnx >> SUB;
        bmin_y = mny >> SUB;
        bmax_x = (mxx + ONE - 1) >> SUB;
        bmax_y = (mxy + ONE - 1) >> SUB;
        if (bmax_x > fw) bmax_x = fw;
        if (bmax_y > fh) bmax_y = fh;
        cx     = bmin_x & 'hFFF;
        cy     = bmin_y & 'hFFF;
        facing = front;
        area_r = ar[AREA_W-1:0];

        // weight i belongs to the edge opposite vertex i
        tl_edges = 3'b000;
        for (int i = 0; i < 3; i++)
        begin
            k  = (i + 1) % 3;
            px = bmin_x * ONE + HALF - vx[k];
            py = bmin_y * ONE + HALF - vy[k];
            wnow[i]      = px * ey[k] - py * ex[k];
            wrow[i]      = wnow[i];
            dlt[2*i]     = ey[k] * ONE;
            dlt[2*i + 1] = -ex[k] * ONE;
            if (ey[k] > 0 || (ey[k] == 0 && ex[k] < 0))
                tl_edges[i] = 1'b1;
        end

        if (bmin_x >= bmax_x || bmin_y >= bmax_y)
            return make_answer(ST_ACCEPTED, bmin_x, bmin_y, front,
                               wnow[0], wnow[1], wnow[2], ar, 1'b1);
        tri_live = 1'b1;
        return make_answer(ST_ACCEPTED, bmin_x, bmin_y, front,
                           wnow[0], wnow[1], wnow[2], ar, 1'b0);
    endfunction

    function automatic pixel_answer_t step_pixel();
        pixel_answer_t a;
        logic          covered, row_end, box_end;
        if (!tri_live)
            return make_answer(ST_NO_TRIANGLE, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        covered = 1'b1;
        for (int i = 0; i < 3; i++)
            if (!(wnow[i] > 0 || (wnow[i] == 0 && tl_edges[i])))
                covered = 1'b0;
        row_end = (cx + 1 >= bmax_x);
        box_end = (cy + 1 >= bmax_y);
        if (covered)
            a = make_answer(ST_COVERED, cx, cy, facing, wnow[0], wnow[1], wnow[2],
                            longint'(area_r), row_end && box_end);
        else
            a = make_answer(ST_NOT_COVERED, cx, cy, facing, wnow[0], wnow[1], wnow[2],
                            longint'(area_r), row_end && box_end);

        if (!row_end)
        begin
            cx = cx + 1;
            for (int i = 0; i < 3; i++)
                wnow[i] += dlt[2*i];
        end
        else
        begin
            // wrap to the start of the next row
            cx = bmin_x & 'hFFF;
            cy = (cy + 1) & 'hFFF;
            for (int i = 0; i < 3; i++)
            begin
                wrow[i] += dlt[2*i + 1];
                wnow[i]  = wrow[i];
            end
            if (box_end)
                tri_live = 1'b0;
        end
        return a;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_fw   = FRAME_WIDTH_RST;
            cfg_fh   = FRAME_HEIGHT_RST;
            cfg_cull = CULL_NONE;
            cfg_wind = WIND_CCW;
            tri_live = 1'b0;
            tl_edges = 3'b000;
            facing   = 1'b0;
            area_r   = '0;
            bmin_x   = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
            cx       = 0; cy = 0;
            for (int i = 0; i < 6; i++)
                dlt[i] = 0;
            for (int i = 0; i < 3; i++)
            begin
                wnow[i] = 0;
                wrow[i] = 0;
            end
            expected_answers.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_FRAME_WIDTH:   cfg_fw   = pwdata[FRAME_W-1:0];
                    REG_FRAME_HEIGHT:  cfg_fh   = pwdata[FRAME_W-1:0];
                    REG_CULL_MODE:     cfg_cull = cull_mode_t'(pwdata[1:0]);
                    REG_FRONT_WINDING: cfg_wind = pwdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_LOAD)
                    expected_answers.push_back(load_triangle(s_tdata));
                else
                    expected_answers.push_back(step_pixel());
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: output beat with nothing pending, expected none, actual %0h",
                             $time, m_tuser);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_answers.pop_front();
                    compare_field("status", oldest.st, m_tuser);
                    compare_field("pixel_x", oldest.px, m_tdata[0 +: PIX_W]);
                    compare_field("pixel_y", oldest.py, m_tdata[PY_AT +: PIX_W]);
                    compare_field("front_facing", oldest.ff, m_tdata[FF_AT]);
                    compare_field("weight_a", oldest.wa, m_tdata[WA_AT +: WEIGHT_W]);
                    compare_field("weight_b", oldest.wb, m_tdata[WB_AT +: WEIGHT_W]);
                    compare_field("weight_c", oldest.wc, m_tdata[WC_AT +: WEIGHT_W]);
                    compare_field("double_area", oldest.area, m_tdata[AR_AT +: AREA_W]);
                    compare_field("last", oldest.last, m_tlast);
                end
            end
            outstanding = expected_answers.size();
        end
    end

endmodule

/* dv/triangle_edge_function_rasterizer_top_tb.sv */
`timescale 1ns / 1ps

module triangle_edge_function_rasterizer_top_tb;
    import tefr_pkg::*;

    localparam int S_TDATA_W   = ((6 * COORD_BITS_DEF + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 5000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    m_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int          outstanding;
    int          mismatches;
    int          snd_idle;
    int          rcv_idle;
    int unsigned cur_fw;
    int unsigned cur_fh;
    int          quiet_cycles = 0;

    always #1 clk = ~clk;

    triangle_edge_function_rasterizer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tefr_coverage_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [S_TDATA_W-1:0] verts(int x0, int y0, int x1, int y1,
                                                   int x2, int y2);
        return {16'(y2), 16'(x2), 16'(y1), 16'(x1), 16'(y0), 16'(x0)};
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(logic req, logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(int unsigned fw, int unsigned fh, cull_mode_t cm, logic wind);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_CULL_MODE, {30'd0, cm});
        write_reg(REG_FRONT_WINDING, {31'd0, wind});
        cur_fw = fw;
        cur_fh = fh;
    endtask

    // mostly small triangles walked to the end of their box, with degenerate,
    // full-range and cut-short runs mixed in
    task automatic random_traffic(int n_items);
        int          sent;
        int          r, w, h, ox, oy, n;
        int unsigned fwe, fhe;
        logic [15:0] c [6];
        sent = 0;
        while (sent < n_items)
        begin
            r   = $urandom_range(99);
            w   = $urandom_range(1, 4);
            h   = $urandom_range(1, 4);
            fwe = (cur_fw > 4096) ? 4096 : cur_fw;
            fhe = (cur_fh > 4096) ? 4096 : cur_fh;
            ox  = $urandom_range(0, fwe);
            oy  = $urandom_range(0, fhe);
            if (ox > 4090) ox = 4090;
            if (oy > 4090) oy = 4090;
            for (int i = 0; i < 3; i++)
            begin
                c[2*i]     = 16'(ox * 16 + $urandom_range(0, w * 16));
                c[2*i + 1] = 16'(oy * 16 + $urandom_range(0, h * 16));
                // snap to pixel centres now and then to land weights on zero
                if ($urandom_range(2) == 0) c[2*i]     = {c[2*i][15:4], 4'd8};
                if ($urandom_range(2) == 0) c[2*i + 1] = {c[2*i + 1][15:4], 4'd8};
            end
            n = (w + 1) * (h + 1) + $urandom_range(0, 1);
            if (r >= 90)
            begin
                for (int i = 0; i < 6; i++)
                    c[i] = 16'($urandom);
                n = $urandom_range(0, 12);
            end
            else if (r >= 80)
            begin
                c[4] = c[2];
                c[5] = c[3];
                n    = $urandom_range(0, 2);
            end
            if ($urandom_range(9) == 0)
                n = $urandom_range(0, n);
            send_beat(REQ_LOAD, {c[5], c[4], c[3], c[2], c[1], c[0]});
            sent++;
            repeat (n)
            begin
                send_beat(REQ_STEP, {$urandom, $urandom, $urandom});
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = REQ_LOAD;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        snd_idle = 21;
        rcv_idle = 59;
        cur_fw   = FRAME_WIDTH_RST;
        cur_fh   = FRAME_HEIGHT_RST;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no triangle, zero area, both windings, extremes, empty box
        send_beat(REQ_STEP, '0);
        send_beat(REQ_LOAD, verts(0, 0, 0, 0, 0, 0));
        send_beat(REQ_LOAD, verts(8, 8, 8, 24, 24, 8));
        repeat (5) send_beat(REQ_STEP, '1);
        send_beat(REQ_LOAD, verts(8, 8, 24, 8, 8, 24));
        repeat (4) send_beat(REQ_STEP, '0);
        send_beat(REQ_LOAD, verts(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF));
        repeat (2) send_beat(REQ_STEP, '0);
        send_beat(REQ_LOAD, verts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF));
        send_beat(REQ_STEP, '0);
        send_beat(REQ_LOAD, verts(16'hFF00, 16'h0100, 16'hFF00, 16'h0200,
                                  16'hFF80, 16'h0100));
        send_beat(REQ_STEP, '0);
        send_beat(REQ_LOAD, verts(0, 0, 16, 16, 32, 32));

        for (int k = 0; k < 6; k++)
        begin
            drain();
            if (k == 2)
            begin
                snd_idle = 59;
                rcv_idle = 21;
            end
            else if (k == 4)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            case (k)
                0: begin apply_setting(640, 480, CULL_NONE, WIND_CCW);   random_traffic(250); end
                1: begin apply_setting(1, 1, CULL_BACK, WIND_CW);        random_traffic(200); end
                2: begin apply_setting(4096, 4096, CULL_FRONT, WIND_CCW); random_traffic(250); end
                3: begin apply_setting(0, 8191, CULL_BOTH, WIND_CW);     random_traffic(60);  end
                4: begin apply_setting(8191, 37, CULL_NONE, WIND_CW);    random_traffic(220); end
                default: begin apply_setting(100, 4096, CULL_BACK, WIND_CCW); random_traffic(220); end
            endcase
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
